// ===== hdl/tcw_pkg.sv =====
package tcw_pkg;

	// screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;

	// field widths of the ports
	localparam int KIND_W = 1;
	localparam int CH_W = 8;
	localparam int IDX_W = 11;
	localparam int CUR_OUT_W = 11;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;
	localparam int START_W = 11;

	// internal widths
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int NXT_W = $clog2(CELLS + COLUMNS + 1);

	// scroll geometry
	localparam int COPY_LEN = (ROWS - 1) * COLUMNS;
	localparam int BOTTOM_ROW = (ROWS - 1) * COLUMNS;

	// character codes
	localparam logic [CH_W-1:0] CHAR_CR = 8'd13;
	localparam logic [CH_W-1:0] CHAR_LF = 8'd10;
	localparam logic [CH_W-1:0] CHAR_SPACE = 8'h20;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
	localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_CURSOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 2'd2;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

	typedef struct packed {
		logic capture;
		logic read_issue;
		logic read_take;
		logic load_start;
		logic load_step;
		logic exec;
		logic copy_step;
		logic blank_step;
		logic clear_step;
		logic cnt_clr;
		logic out_load;
	} tcw_cmd_t;

	typedef struct packed {
		logic kind_rd;
		logic mirror;
		logic loaded;
		logic rem_ge;
		logic scroll_req;
		logic copy_last;
		logic blank_last;
		logic clear_last;
		logic out_free;
	} tcw_status_t;

endpackage

// ===== hdl/text_console_char_writer.sv =====
// text-mode console engine: a screen store of 80x25 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor. a write request
// (kind 0) with mirror_enable set stores the character at the cursor and
// advances it, or handles carriage return / line feed; passing the last cell
// scrolls the screen up one row and blanks the bottom row with spaces. a read
// request (kind 1) returns one cell. every request gives exactly one response
// on the out channel. after reset the store is swept to zero, one cell a cycle,
// while in_ready stays low (configuration writes are always taken). a request
// is accepted only when the previous one has loaded its response. the first
// enabled character request first splits the start cursor into row and column
// by repeated subtraction. a scroll copies the rows up and then blanks the
// bottom row, one cell at a time through the single write port of the store.
// the next request is accepted while a finished response waits on the out
// channel; a request only stalls at its end if that response is still unread.
module text_console_char_writer (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tcw_pkg::KIND_W-1:0]          kind,
	input  logic [tcw_pkg::CH_W-1:0]            ch,
	input  logic [tcw_pkg::IDX_W-1:0]           cell_index,
	// response channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tcw_pkg::CUR_OUT_W-1:0]       cursor,
	output logic [tcw_pkg::CELL_W-1:0]          cell_data,
	output logic                                wrote_cell,
	output logic                                scrolled,
	// configuration: 0 mirror_enable, 1 start_cursor, 2 attribute
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tcw_pkg::*;

	tcw_cmd_t    cmd;
	tcw_status_t st;

	// sequencer: clear sweep, decode, cursor load, execute, scroll, respond
	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// screen store, cursor, config registers and response register
	tcw_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.kind       (kind),
		.ch         (ch),
		.cell_index (cell_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor     (cursor),
		.cell_data  (cell_data),
		.wrote_cell (wrote_cell),
		.scrolled   (scrolled),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

endmodule

// ===== hdl/tcw_ctrl.sv =====
module tcw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tcw_pkg::tcw_status_t st,
	output tcw_pkg::tcw_cmd_t    cmd
);
	import tcw_pkg::*;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECODE = 4'd2;
	localparam logic [3:0] S_LOAD   = 4'd3;
	localparam logic [3:0] S_EXEC   = 4'd4;
	localparam logic [3:0] S_COPY   = 4'd5;
	localparam logic [3:0] S_BLANK  = 4'd6;
	localparam logic [3:0] S_READ   = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (st.clear_last) begin
					cmd.cnt_clr = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.kind_rd) begin
					cmd.read_issue = 1'b1;
					state_d = S_READ;
				end else if (!st.mirror) begin
					state_d = S_DONE;
				end else if (!st.loaded) begin
					cmd.load_start = 1'b1;
					state_d = S_LOAD;
				end else begin
					state_d = S_EXEC;
				end
			end
			S_LOAD: begin
				cmd.load_step = 1'b1;
				if (!st.rem_ge) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (st.scroll_req) begin
					cmd.cnt_clr = 1'b1;
					state_d = S_COPY;
				end else begin
					state_d = S_DONE;
				end
			end
			S_COPY: begin
				cmd.copy_step = 1'b1;
				if (st.copy_last) begin
					cmd.cnt_clr = 1'b1;
					state_d = S_BLANK;
				end
			end
			S_BLANK: begin
				cmd.blank_step = 1'b1;
				if (st.blank_last) begin
					cmd.cnt_clr = 1'b1;
					state_d = S_DONE;
				end
			end
			S_READ: begin
				cmd.read_take = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/tcw_datapath.sv =====
module tcw_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tcw_pkg::tcw_cmd_t                   cmd,
	output tcw_pkg::tcw_status_t                st,
	input  logic [tcw_pkg::KIND_W-1:0]          kind,
	input  logic [tcw_pkg::CH_W-1:0]            ch,
	input  logic [tcw_pkg::IDX_W-1:0]           cell_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tcw_pkg::CUR_OUT_W-1:0]       cursor,
	output logic [tcw_pkg::CELL_W-1:0]          cell_data,
	output logic                                wrote_cell,
	output logic                                scrolled,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tcw_pkg::*;

	// configuration registers
	logic              mirror_q;
	logic [START_W-1:0] start_q;
	logic [ATTR_W-1:0] attr_q;

	// captured request
	logic [KIND_W-1:0] kind_q;
	logic [CH_W-1:0]   ch_q;
	logic [IDX_W-1:0]  idx_q;

	// cursor state
	logic [ADDR_W-1:0] cursor_q;
	logic [COL_W-1:0]  col_q;
	logic              loaded_q;
	logic [ADDR_W-1:0] rem_q;

	// sweep counter and per-request results
	logic [ADDR_W-1:0] cnt_q;
	logic [CELL_W-1:0] res_data_q;
	logic              res_wrote_q;
	logic              res_scr_q;

	// output register
	logic                 out_valid_q;
	logic [CUR_OUT_W-1:0] out_cursor_q;
	logic [CELL_W-1:0]    out_data_q;
	logic                 out_wrote_q;
	logic                 out_scr_q;

	// screen store
	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [CELL_W-1:0] wdata;
	logic              we;

	logic              is_cr;
	logic              is_lf;
	logic              printable;
	logic              idx_ok;
	logic              copy_rd;
	logic [ADDR_W-1:0] start_ok;
	logic [NXT_W-1:0]  nxt;
	logic [COL_W-1:0]  col_inc;

	assign is_cr = (ch_q == CHAR_CR);
	assign is_lf = (ch_q == CHAR_LF);
	assign printable = !is_cr && !is_lf;
	assign idx_ok = (32'(idx_q) < CELLS);
	assign copy_rd = (32'(cnt_q) < COPY_LEN);
	assign start_ok = (32'(start_q) < CELLS) ? ADDR_W'(start_q) : '0;
	assign col_inc = (32'(col_q) == COLUMNS - 1) ? '0 : col_q + COL_W'(1);

	// next cursor position before any scroll
	always_comb begin
		if (is_lf) begin
			nxt = NXT_W'(cursor_q) + NXT_W'(COLUMNS) - NXT_W'(col_q);
		end else begin
			nxt = NXT_W'(cursor_q) + NXT_W'(1);
		end
	end

	always_comb begin
		st.kind_rd = (kind_q == KIND_READ);
		st.mirror = mirror_q;
		st.loaded = loaded_q;
		st.rem_ge = (32'(rem_q) >= COLUMNS);
		st.scroll_req = !is_cr && (32'(nxt) >= CELLS);
		st.copy_last = (32'(cnt_q) == COPY_LEN);
		st.blank_last = (32'(cnt_q) == COLUMNS - 1);
		st.clear_last = (32'(cnt_q) == CELLS - 1);
		st.out_free = !out_valid_q || out_ready;
	end

	// read port address: request read or scroll source row
	always_comb begin
		if (cmd.read_issue && idx_ok) begin
			raddr = ADDR_W'(idx_q);
		end else if (cmd.copy_step && copy_rd) begin
			raddr = cnt_q + ADDR_W'(COLUMNS);
		end else begin
			raddr = '0;
		end
	end

	// write port: clear sweep, scroll copy, bottom row blank, character store
	always_comb begin
		we = 1'b0;
		waddr = cursor_q;
		wdata = {attr_q, ch_q};
		if (cmd.clear_step) begin
			we = 1'b1;
			waddr = cnt_q;
			wdata = '0;
		end else if (cmd.copy_step) begin
			we = (cnt_q != '0);
			waddr = cnt_q - ADDR_W'(1);
			wdata = rdata_q;
		end else if (cmd.blank_step) begin
			we = 1'b1;
			waddr = ADDR_W'(BOTTOM_ROW) + cnt_q;
			wdata = {attr_q, CHAR_SPACE};
		end else if (cmd.exec && printable) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// configuration writes, unknown index ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
			start_q <= '0;
			attr_q <= ATTR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIRROR_ENABLE: mirror_q <= cfg_data[0];
				REG_START_CURSOR: start_q <= START_W'(cfg_data);
				REG_ATTRIBUTE: attr_q <= ATTR_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// request capture and results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			ch_q <= ch;
			idx_q <= cell_index;
		end
		if (cmd.load_start) begin
			rem_q <= start_ok;
		end else if (cmd.load_step && st.rem_ge) begin
			rem_q <= rem_q - ADDR_W'(COLUMNS);
		end
		if (cmd.capture) begin
			res_data_q <= '0;
			res_wrote_q <= 1'b0;
			res_scr_q <= 1'b0;
		end else if (cmd.read_take) begin
			res_data_q <= idx_ok ? rdata_q : '0;
		end else if (cmd.exec) begin
			res_wrote_q <= printable;
			res_scr_q <= st.scroll_req;
		end
		if (cmd.out_load) begin
			out_cursor_q <= CUR_OUT_W'(cursor_q);
			out_data_q <= res_data_q;
			out_wrote_q <= res_wrote_q;
			out_scr_q <= res_scr_q;
		end
	end

	// cursor and column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q <= '0;
			loaded_q <= 1'b0;
		end else if (cmd.load_start) begin
			cursor_q <= start_ok;
		end else if (cmd.load_step && !st.rem_ge) begin
			col_q <= COL_W'(rem_q);
			loaded_q <= 1'b1;
		end else if (cmd.exec) begin
			if (is_cr) begin
				cursor_q <= cursor_q - ADDR_W'(col_q);
				col_q <= '0;
			end else if (st.scroll_req) begin
				cursor_q <= ADDR_W'(BOTTOM_ROW);
				col_q <= '0;
			end else begin
				cursor_q <= ADDR_W'(nxt);
				col_q <= is_lf ? '0 : col_inc;
			end
		end
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.clear_step || cmd.copy_step || cmd.blank_step) begin
			cnt_q <= cnt_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign cursor = out_cursor_q;
	assign cell_data = out_data_q;
	assign wrote_cell = out_wrote_q;
	assign scrolled = out_scr_q;

endmodule
